>>> sv/iirdf1_pkg.sv
// Shared types and constants for the direct form I IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package iirdf1_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COEFF_W  = 32;
    localparam int ORDER_W  = 2;
    localparam int INDEX_W  = 3;

    // Highest filter order that the datapath supports.
    localparam logic [ORDER_W-1:0] MAX_ORDER = 2'd2;

    // Fraction bits of the Q4.28 coefficients.
    localparam int FRAC_SHIFT = 28;

    // Reset value of coeff_b0: 1.0 in Q4.28.
    localparam logic signed [COEFF_W-1:0] B0_RESET = 32'sh1000_0000;

    // Command carried in tuser.
    typedef enum logic [1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_PREFILL = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [INDEX_W-1:0] {
        REG_ORDER = 3'd0,
        REG_B0    = 3'd1,
        REG_B1    = 3'd2,
        REG_B2    = 3'd3,
        REG_A1    = 3'd4,
        REG_A2    = 3'd5
    } reg_index_t;

    // Coefficient set handed to the multiply-accumulate datapath.
    typedef struct packed {
        logic signed [COEFF_W-1:0] b0;
        logic signed [COEFF_W-1:0] b1;
        logic signed [COEFF_W-1:0] b2;
        logic signed [COEFF_W-1:0] a1;
        logic signed [COEFF_W-1:0] a2;
    } coeff_t;

    // Sample history: x1/y1 are one sample old, x2/y2 two samples old.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } history_t;

endpackage

`default_nettype wire

>>> sv/iirdf1_mac.sv
// Combinational multiply-accumulate, rounding and saturation for one sample.
`timescale 1ns / 1ps
`default_nettype none

module iirdf1_mac (
    input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_i,
    input  wire iirdf1_pkg::history_t                   hist_i,
    input  wire iirdf1_pkg::coeff_t                     coeff_i,
    input  wire logic [iirdf1_pkg::ORDER_W-1:0]         order_i,
    output logic signed [iirdf1_pkg::SAMPLE_W-1:0]      y_o
);

    localparam int PROD_W = iirdf1_pkg::SAMPLE_W + iirdf1_pkg::COEFF_W;
    // Five products plus sign growth.
    localparam int SUM_W  = PROD_W + 3;
    localparam int Q_W    = SUM_W - iirdf1_pkg::FRAC_SHIFT;

    localparam logic signed [SUM_W-1:0] HALF_LSB =
        SUM_W'(64'd1 << (iirdf1_pkg::FRAC_SHIFT - 1));
    localparam logic signed [Q_W-1:0] Y_MAX = Q_W'(64'sd2147483647);
    localparam logic signed [Q_W-1:0] Y_MIN = -Q_W'(64'sd2147483648);

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [PROD_W-1:0] t_b1, t_b2, t_a1, t_a2;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic signed [Q_W-1:0]    q;
    logic                     use_tap1, use_tap2;

    assign p_b0 = coeff_i.b0 * x_i;
    assign p_b1 = coeff_i.b1 * hist_i.x1;
    assign p_b2 = coeff_i.b2 * hist_i.x2;
    assign p_a1 = coeff_i.a1 * hist_i.y1;
    assign p_a2 = coeff_i.a2 * hist_i.y2;

    assign use_tap1 = (order_i >= 2'd1);
    assign use_tap2 = (order_i >= 2'd2);

    // Feedback products enter the sum negated; a negated product still fits.
    assign t_b1 = use_tap1 ? p_b1  : '0;
    assign t_a1 = use_tap1 ? -p_a1 : '0;
    assign t_b2 = use_tap2 ? p_b2  : '0;
    assign t_a2 = use_tap2 ? -p_a2 : '0;

    assign sum = SUM_W'(p_b0) + SUM_W'(t_b1) + SUM_W'(t_a1)
               + SUM_W'(t_b2) + SUM_W'(t_a2);

    // Round half up to Q16.16, then clamp to the 32-bit range.
    assign sum_rnd = sum + HALF_LSB;
    assign q       = sum_rnd[SUM_W-1:iirdf1_pkg::FRAC_SHIFT];

    always_comb begin
        if (q > Y_MAX) begin
            y_o = Y_MAX[iirdf1_pkg::SAMPLE_W-1:0];
        end else if (q < Y_MIN) begin
            y_o = Y_MIN[iirdf1_pkg::SAMPLE_W-1:0];
        end else begin
            y_o = q[iirdf1_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/iir_direct_form_one_filter.sv
// Top level of the direct form I IIR filter of order zero to two.
//
// Usage: words arrive on the s_ channel. s_tuser carries the command
// (sample, clear history, prefill history) and s_tdata the Q16.16 value.
// Each sample command yields one Q16.16 word on the m_ channel,
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded half up and saturated
// to 32 bits; clear and prefill commands yield no word. Taps beyond
// filter_order are left out of the sum; orders above two act as two.
// Coefficients and the order are to be written by the user through the cfg_
// port only while the filter is idle; the block itself does not enforce it.
// Path: an accepted sample word is held in the input register and its
// result is registered in the result register that drives m_tdata.
// Throughput: one word per cycle unless a sample word waits on a stalled
// receiver, set by the feedback path from the history through the five
// multipliers, the adder and the saturation stage, which is combinational.
// Reset clears the pipeline, the history and loads the reset coefficients.
// When the receiver stalls, the result register holds its word; the input
// register keeps taking clear and prefill words and stops only when a
// sample word would need the occupied result register.
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_one_filter (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Input channel.
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [iirdf1_pkg::SAMPLE_W-1:0]       s_tdata,  // [31:0] sample_value
    input  wire logic [1:0]                            s_tuser,  // [1:0] command
    // Result channel.
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [iirdf1_pkg::SAMPLE_W-1:0]            m_tdata,  // [31:0] filtered_value
    // Configuration write port.
    input  wire logic                                  cfg_wr_en,
    input  wire logic [iirdf1_pkg::INDEX_W-1:0]        cfg_index,
    input  wire logic [iirdf1_pkg::COEFF_W-1:0]        cfg_wdata
);

    // Configuration registers.
    logic [iirdf1_pkg::ORDER_W-1:0] order_reg;
    iirdf1_pkg::coeff_t             coeff_reg;

    // Input register.
    logic                                 in_valid_reg;
    iirdf1_pkg::cmd_t                     in_cmd_reg;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] in_value_reg;

    // Filter history and result register.
    iirdf1_pkg::history_t                 hist_reg, hist_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic                                 s_accept;
    logic                                 advance;
    logic                                 is_sample;
    logic [iirdf1_pkg::ORDER_W-1:0]       order_eff;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_calc;

    // The held word may leave the input register unless it is a sample
    // and the result register is occupied by a word the receiver has not taken.
    assign is_sample = (in_cmd_reg == iirdf1_pkg::CMD_SAMPLE);
    assign advance   = in_valid_reg && (!is_sample || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    assign order_eff = (order_reg > iirdf1_pkg::MAX_ORDER) ? iirdf1_pkg::MAX_ORDER
                                                           : order_reg;

    iirdf1_mac u_mac (
        .x_i     (in_value_reg),
        .hist_i  (hist_reg),
        .coeff_i (coeff_reg),
        .order_i (order_eff),
        .y_o     (y_calc)
    );

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg    <= '0;
            coeff_reg.b0 <= iirdf1_pkg::B0_RESET;
            coeff_reg.b1 <= '0;
            coeff_reg.b2 <= '0;
            coeff_reg.a1 <= '0;
            coeff_reg.a2 <= '0;
        end else if (cfg_wr_en) begin
            case (iirdf1_pkg::reg_index_t'(cfg_index))
                iirdf1_pkg::REG_ORDER: order_reg    <= cfg_wdata[iirdf1_pkg::ORDER_W-1:0];
                iirdf1_pkg::REG_B0:    coeff_reg.b0 <= cfg_wdata;
                iirdf1_pkg::REG_B1:    coeff_reg.b1 <= cfg_wdata;
                iirdf1_pkg::REG_B2:    coeff_reg.b2 <= cfg_wdata;
                iirdf1_pkg::REG_A1:    coeff_reg.a1 <= cfg_wdata;
                iirdf1_pkg::REG_A2:    coeff_reg.a2 <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: loads whenever a word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg   <= iirdf1_pkg::cmd_t'(s_tuser);
            in_value_reg <= s_tdata;
        end
    end

    // Next history and result for the word leaving the input register.
    // Command code three leaves everything unchanged.
    always_comb begin
        hist_next      = hist_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (advance) begin
            case (in_cmd_reg)
                iirdf1_pkg::CMD_SAMPLE: begin
                    hist_next.x2   = hist_reg.x1;
                    hist_next.x1   = in_value_reg;
                    hist_next.y2   = hist_reg.y1;
                    hist_next.y1   = y_calc;
                    out_data_next  = y_calc;
                    out_valid_next = 1'b1;
                end
                iirdf1_pkg::CMD_CLEAR: begin
                    hist_next = '0;
                end
                iirdf1_pkg::CMD_PREFILL: begin
                    hist_next.x1 = in_value_reg;
                    hist_next.x2 = in_value_reg;
                    hist_next.y1 = in_value_reg;
                    hist_next.y2 = in_value_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A processed sample shows its result and the same value becomes y1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_sample) |=> (out_valid_reg && out_data_reg == hist_reg.y1
                                    && hist_reg.y2 == $past(hist_reg.y1)))
        else $error("sample result and output history disagree");

    // Clear empties both history lines.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == iirdf1_pkg::CMD_CLEAR) |=> (hist_reg == '0))
        else $error("clear did not zero the history");

    // Prefill loads all four history entries with the value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_cmd_reg == iirdf1_pkg::CMD_PREFILL) |=>
            (hist_reg.x1 == $past(in_value_reg) && hist_reg.x2 == $past(in_value_reg)
             && hist_reg.y1 == $past(in_value_reg) && hist_reg.y2 == $past(in_value_reg)))
        else $error("prefill did not load the history");

    // A word that is not a sample never creates a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_sample && (!out_valid_reg || m_tready)) |=> !out_valid_reg)
        else $error("result produced for a non-sample command");

    // A stalled sample holds the input register and leaves history untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && is_sample && out_valid_reg && !m_tready) |=>
            (in_valid_reg && $stable(hist_reg)))
        else $error("stalled sample was lost or history moved");

endmodule

`default_nettype wire

>>> sim/tb_iir_direct_form_one_filter.sv
// Self-checking testbench for the direct form I IIR filter.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the filter registers and history, predicts
// the filtered word for every accepted sample word and checks the results.
class filter_scoreboard;
    logic [iirdf1_pkg::ORDER_W-1:0]         order;
    logic signed [iirdf1_pkg::COEFF_W-1:0]  b0, b1, b2, a1, a2;
    logic signed [iirdf1_pkg::SAMPLE_W-1:0] x1, x2, y1, y2;
    logic [iirdf1_pkg::SAMPLE_W-1:0]        expected_outputs[$];
    int errors, n_sample, n_clear, n_prefill, n_ignored, n_checked;

    function new();
        order = '0;
        b0 = iirdf1_pkg::B0_RESET;
        b1 = '0;
        b2 = '0;
        a1 = '0;
        a2 = '0;
        x1 = '0;
        x2 = '0;
        y1 = '0;
        y2 = '0;
        errors = 0;
        n_sample = 0;
        n_clear = 0;
        n_prefill = 0;
        n_ignored = 0;
        n_checked = 0;
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    function void set_register(iirdf1_pkg::reg_index_t idx,
                               logic [iirdf1_pkg::COEFF_W-1:0] value);
        case (idx)
            iirdf1_pkg::REG_ORDER: order = value[iirdf1_pkg::ORDER_W-1:0];
            iirdf1_pkg::REG_B0:    b0 = value;
            iirdf1_pkg::REG_B1:    b1 = value;
            iirdf1_pkg::REG_B2:    b2 = value;
            iirdf1_pkg::REG_A1:    a1 = value;
            iirdf1_pkg::REG_A2:    a2 = value;
            default:   ;
        endcase
    endfunction

    // Exact 64-bit product, widened so that five of them can be summed.
    function logic signed [69:0] wide_product(logic signed [31:0] c, logic signed [31:0] v);
        logic signed [69:0] wc;
        logic signed [69:0] wv;
        wc = c;
        wv = v;
        return wc * wv;
    endfunction

    function logic signed [iirdf1_pkg::SAMPLE_W-1:0] predict_filtered(
        logic signed [iirdf1_pkg::SAMPLE_W-1:0] x);
        logic signed [69:0]  acc;
        logic signed [69:0]  rnd;
        logic [iirdf1_pkg::ORDER_W-1:0] taps;
        taps = (order > iirdf1_pkg::MAX_ORDER) ? iirdf1_pkg::MAX_ORDER : order;
        acc = wide_product(b0, x);
        if (taps >= 1)
            acc = acc + wide_product(b1, x1) - wide_product(a1, y1);
        if (taps >= 2)
            acc = acc + wide_product(b2, x2) - wide_product(a2, y2);
        // Round half up from Q x.44 products to Q16.16, then clamp.
        rnd = (acc + 70'sd134217728) >>> iirdf1_pkg::FRAC_SHIFT;
        if (rnd > 70'sd2147483647)
            return 32'sh7fff_ffff;
        if (rnd < -70'sd2147483648)
            return 32'sh8000_0000;
        return rnd[iirdf1_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_input(logic [1:0] cmd, logic [iirdf1_pkg::SAMPLE_W-1:0] value);
        logic signed [iirdf1_pkg::SAMPLE_W-1:0] y;
        case (cmd)
            iirdf1_pkg::CMD_SAMPLE: begin
                y = predict_filtered(value);
                x2 = x1;
                x1 = value;
                y2 = y1;
                y1 = y;
                expected_outputs.push_back(y);
                n_sample++;
            end
            iirdf1_pkg::CMD_CLEAR: begin
                x1 = '0;
                x2 = '0;
                y1 = '0;
                y2 = '0;
                n_clear++;
            end
            iirdf1_pkg::CMD_PREFILL: begin
                x1 = value;
                x2 = value;
                y1 = value;
                y2 = value;
                n_prefill++;
            end
            default: n_ignored++;
        endcase
    endfunction

    task check_result(logic [iirdf1_pkg::SAMPLE_W-1:0] got);
        logic [iirdf1_pkg::SAMPLE_W-1:0] want;
        if (expected_outputs.size() == 0) begin
            report_mismatch($sformatf("filtered_value %h arrived with nothing expected", got));
        end else begin
            want = expected_outputs.pop_front();
            n_checked++;
            if (got !== want)
                report_mismatch($sformatf("filtered_value got %h, expected %h", got, want));
        end
    endtask

    function int pending();
        return expected_outputs.size();
    endfunction

    task check_leftover();
        if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d expected filtered words never arrived",
                                      expected_outputs.size()));
    endtask
endclass

module tb_iir_direct_form_one_filter;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest legal stretch is a drain plus a register update, well below this.
    localparam int STALL_LIMIT = 4000;

    // The one command code the package does not name: the filter ignores it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Handy Q4.28 and Q16.16 corner values.
    localparam logic [31:0] POS_FULL = 32'h7fff_ffff;
    localparam logic [31:0] NEG_FULL = 32'h8000_0000;
    localparam logic [31:0] ONE_Q428 = 32'h1000_0000;
    localparam logic [31:0] HALF_Q428 = 32'h0800_0000;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [iirdf1_pkg::SAMPLE_W-1:0] s_tdata = '0;                    // [31:0] sample_value
    logic [1:0]                      s_tuser = iirdf1_pkg::CMD_SAMPLE; // [1:0] command
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [iirdf1_pkg::SAMPLE_W-1:0] m_tdata;                    // [31:0] filtered_value
    logic                            cfg_wr_en = 1'b0;
    iirdf1_pkg::reg_index_t          cfg_index = iirdf1_pkg::REG_ORDER;
    logic [iirdf1_pkg::COEFF_W-1:0]  cfg_wdata = '0;

    // Idle rates in percent for the sender and the receiver, plus counters
    // for stretches in which the side does not idle at all.
    int tx_idle_pct = 38;
    int rx_idle_pct = 74;
    int tx_quiet = 0;
    int rx_quiet = 0;
    int stall_cycles = 0;
    int settings_used = 0;

    filter_scoreboard sb;

    always #1 aclk = ~aclk;

    iir_direct_form_one_filter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Receiver: stalls at the current rate, with an occasional stretch in
    // which it takes every word.
    always @(posedge aclk) begin
        if (rx_quiet > 0) begin
            rx_quiet = rx_quiet - 1;
            m_tready <= 1'b1;
        end else begin
            if ($urandom_range(299) == 0)
                rx_quiet = $urandom_range(60, 20);
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor and watchdog. Both channels are sampled at the rising edge,
    // before any of this edge's updates land. A result accepted at an edge
    // always belongs to an earlier sample word, so checking it before noting
    // the input word of the same edge keeps the queue in order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offers one word and returns after the edge at which it was taken. The
    // valid is dropped only for idle cycles, so back-to-back words keep it
    // high without a glitch.
    task automatic send_word(input logic [1:0] cmd,
                             input logic [iirdf1_pkg::SAMPLE_W-1:0] value);
        if (tx_quiet > 0) begin
            tx_quiet--;
        end else begin
            if ($urandom_range(99) == 0)
                tx_quiet = $urandom_range(50, 20);
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Stops sending and waits until every predicted word has come back. Clear
    // and prefill words give no result, so it then waits on to let the last
    // of them pass the two-stage pipeline before any register is touched.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input iirdf1_pkg::reg_index_t idx,
                             input logic [iirdf1_pkg::COEFF_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.set_register(idx, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [iirdf1_pkg::COEFF_W-1:0] order,
                             input logic [iirdf1_pkg::COEFF_W-1:0] nb0,
                             input logic [iirdf1_pkg::COEFF_W-1:0] nb1,
                             input logic [iirdf1_pkg::COEFF_W-1:0] nb2,
                             input logic [iirdf1_pkg::COEFF_W-1:0] na1,
                             input logic [iirdf1_pkg::COEFF_W-1:0] na2);
        write_reg(iirdf1_pkg::REG_ORDER, order);
        write_reg(iirdf1_pkg::REG_B0, nb0);
        write_reg(iirdf1_pkg::REG_B1, nb1);
        write_reg(iirdf1_pkg::REG_B2, nb2);
        write_reg(iirdf1_pkg::REG_A1, na1);
        write_reg(iirdf1_pkg::REG_A2, na2);
        settings_used++;
    endtask

    // Coefficient styles: 0 is within +/-0.5 so the feedback stays stable,
    // 1 is any 32-bit value, 2 picks among the corners.
    function automatic logic [iirdf1_pkg::COEFF_W-1:0] rand_coeff(int style);
        case (style)
            0: return 32'($urandom_range(32'h1000_0000)) - HALF_Q428;
            1: return $urandom();
            default: begin
                case ($urandom_range(4))
                    0: return POS_FULL;
                    1: return NEG_FULL;
                    2: return ONE_Q428;
                    3: return -ONE_Q428;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Samples: half are any 32-bit value, the rest small values near zero or
    // the corners of the range.
    function automatic logic [iirdf1_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(3))
            1: return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            2: begin
                case ($urandom_range(3))
                    0: return POS_FULL;
                    1: return NEG_FULL;
                    2: return 32'hffff_ffff;
                    default: return '0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int phase;
        int style;
        int counted;
        int pick;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, first with the reset registers: order zero and b0
        // at 1.0 pass every sample through unchanged, corners included. A
        // prefill and an unknown command sit in between and give no word.
        settings_used = 1;
        send_word(iirdf1_pkg::CMD_SAMPLE, POS_FULL);
        send_word(iirdf1_pkg::CMD_SAMPLE, NEG_FULL);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hffff_ffff);
        send_word(iirdf1_pkg::CMD_PREFILL, 32'h1234_5678);
        send_word(CMD_UNUSED, 32'hdead_beef);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0001_8000);

        // Every coefficient at a corner with order two: the sums overflow
        // both ways and the clamped value must be what feeds back.
        wait_for_results();
        configure(2, POS_FULL, NEG_FULL, POS_FULL, NEG_FULL, POS_FULL);
        send_word(iirdf1_pkg::CMD_SAMPLE, POS_FULL);
        send_word(iirdf1_pkg::CMD_SAMPLE, NEG_FULL);
        send_word(iirdf1_pkg::CMD_PREFILL, NEG_FULL);
        send_word(iirdf1_pkg::CMD_SAMPLE, '0);
        send_word(iirdf1_pkg::CMD_CLEAR, 32'h5555_aaaa);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0000_0001);

        // Order three must behave as order two.
        wait_for_results();
        configure(3, HALF_Q428, 32'h0400_0000, 32'hfc00_0000, 32'hf000_0000, 32'h0200_0000);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0001_0000);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hffff_0000);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0000_8000);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hffff_8000);

        // Order lowered with history kept: the taps simply drop out.
        wait_for_results();
        write_reg(iirdf1_pkg::REG_ORDER, 1);
        settings_used++;
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0003_0000);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hfffd_0000);

        // Order zero with b0 at one half: odd samples land exactly halfway
        // and must round up, toward plus infinity, on both signs.
        wait_for_results();
        write_reg(iirdf1_pkg::REG_ORDER, 0);
        settings_used++;
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0000_0001);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hffff_ffff);
        send_word(CMD_UNUSED, '0);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'h0000_0003);
        send_word(iirdf1_pkg::CMD_SAMPLE, 32'hffff_fffd);

        // Random part in ten phases. Each phase starts from an idle filter
        // with new registers; every fourth one only changes the order and so
        // keeps the coefficients and the history. The first three phases
        // stall the receiver more, the next three the sender, the rest none.
        for (phase = 0; phase < 10; phase++) begin
            wait_for_results();
            if (phase < 3) begin
                tx_idle_pct = 38;
                rx_idle_pct = 74;
            end else if (phase < 6) begin
                tx_idle_pct = 74;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            style = phase % 4;
            if (style == 3) begin
                write_reg(iirdf1_pkg::REG_ORDER, $urandom_range(3));
                settings_used++;
            end else begin
                configure($urandom_range(3), rand_coeff(style), rand_coeff(style),
                          rand_coeff(style), rand_coeff(style), rand_coeff(style));
            end
            counted = 0;
            while (counted < 125) begin
                pick = $urandom_range(99);
                if (pick < 82) begin
                    send_word(iirdf1_pkg::CMD_SAMPLE, rand_sample());
                    counted++;
                end else if (pick < 89) begin
                    send_word(iirdf1_pkg::CMD_CLEAR, $urandom());
                    counted++;
                end else if (pick < 95) begin
                    send_word(iirdf1_pkg::CMD_PREFILL, rand_sample());
                    counted++;
                end else begin
                    send_word(CMD_UNUSED, $urandom());
                end
                // Now and then the sender holds off until the filter is empty.
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        sb.check_leftover();

        $display("Covered %0d sample, %0d clear, %0d prefill and %0d ignored words",
                 sb.n_sample, sb.n_clear, sb.n_prefill, sb.n_ignored);
        $display("under %0d register settings; %0d filtered words checked, %0d mismatches.",
                 settings_used, sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
sv/iirdf1_pkg.sv
sv/iirdf1_mac.sv
sv/iir_direct_form_one_filter.sv
sim/tb_iir_direct_form_one_filter.sv
